// ===== hdl/pdh_pkg.sv =====
// pair difference histogram package: request and status codes, controller states, cordic constants and arctangent table
// no dependencies
`timescale 1ns / 1ps

package pdh_pkg;

    typedef enum logic [1:0] {
        REQ_ACCUM = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_SKIP     = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_NOBIN    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_CORDIC1,
        S_CORDIC2,
        S_BIN,
        S_READ,
        S_WRITE,
        S_OUT
    } state_t;

    localparam int CordicSteps = 16;
    localparam int CordicWidth = 28;

    function automatic logic [15:0] atan_bam(input logic [3:0] i);
        case (i)
            4'd0:    atan_bam = 16'd8192;
            4'd1:    atan_bam = 16'd4836;
            4'd2:    atan_bam = 16'd2555;
            4'd3:    atan_bam = 16'd1297;
            4'd4:    atan_bam = 16'd651;
            4'd5:    atan_bam = 16'd326;
            4'd6:    atan_bam = 16'd163;
            4'd7:    atan_bam = 16'd81;
            4'd8:    atan_bam = 16'd41;
            4'd9:    atan_bam = 16'd20;
            4'd10:   atan_bam = 16'd10;
            4'd11:   atan_bam = 16'd5;
            4'd12:   atan_bam = 16'd3;
            4'd13:   atan_bam = 16'd1;
            4'd14:   atan_bam = 16'd1;
            default: atan_bam = 16'd0;
        endcase
    endfunction

endpackage

// ===== hdl/pdh_if.sv =====
// valid/ready channel interfaces for requests, results and configuration
// no dependencies
`timescale 1ns / 1ps

interface pdh_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [15:0] rapidity_first;
    logic signed [15:0] momx_first;
    logic signed [15:0] momy_first;
    logic signed [31:0] code_first;
    logic signed [15:0] rapidity_second;
    logic signed [15:0] momx_second;
    logic signed [15:0] momy_second;
    logic signed [31:0] code_second;
    logic [4:0]         bin_index;
    modport source (output valid, req_type, rapidity_first, momx_first, momy_first,
                    code_first, rapidity_second, momx_second, momy_second, code_second,
                    bin_index, input ready);
    modport sink (input valid, req_type, rapidity_first, momx_first, momy_first,
                  code_first, rapidity_second, momx_second, momy_second, code_second,
                  bin_index, output ready);
endinterface

interface pdh_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] rapidity_count;
    logic [31:0] angle_count;
    logic [31:0] pairs_counted;
    logic [4:0]  rapidity_bin_hit;
    logic [4:0]  angle_bin_hit;
    modport source (output valid, status, rapidity_count, angle_count, pairs_counted,
                    rapidity_bin_hit, angle_bin_hit, input ready);
    modport sink (input valid, status, rapidity_count, angle_count, pairs_counted,
                  rapidity_bin_hit, angle_bin_hit, output ready);
endinterface

interface pdh_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] species_code;
    modport source (output valid, species_code, input ready);
    modport sink (input valid, species_code, output ready);
endinterface

// ===== hdl/pdh_cordic.sv =====
// iterative vectoring cordic, one micro-rotation per cycle, 16-bit binary angle out
// depends on pdh_pkg
`timescale 1ns / 1ps

module pdh_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] vec_x,
    input  logic signed [15:0] vec_y,
    output logic               done,
    output logic [15:0]        angle
);
    import pdh_pkg::*;

    logic signed [CordicWidth-1:0] x_reg, x_next, y_reg, y_next;
    logic [15:0] z_reg, z_next;
    logic [3:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic signed [CordicWidth-1:0] x0, y0, xs, ys;
    logic zero_vec;

    always_comb
    begin
        zero_vec = (vec_x == 16'sd0) && (vec_y == 16'sd0);
        if (vec_x < 0)
        begin
            x0 = -(CordicWidth'(vec_x) <<< 8);
            y0 = -(CordicWidth'(vec_y) <<< 8);
        end
        else
        begin
            x0 = CordicWidth'(vec_x) <<< 8;
            y0 = CordicWidth'(vec_y) <<< 8;
        end
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next = x0;
            y_next = y0;
            z_next = (vec_x < 0) ? 16'd32768 : 16'd0;
            step_next = 4'd0;
            busy_next = !zero_vec;
            done_next = zero_vec;
            if (zero_vec)
                z_next = 16'd0;
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_bam(step_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_bam(step_reg);
            end
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(CordicSteps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("cordic done while busy");
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("cordic restarted while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg || $past(start)) else $error("cordic done held");
endmodule

// ===== hdl/pdh_hist_mem.sv =====
// histogram store: one synchronous memory, one read and one write port
// depends on nothing but the parameters given
`timescale 1ns / 1ps

module pdh_hist_mem #(
    parameter int DEPTH = 20,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);
    logic [31:0] mem [DEPTH];
    logic [31:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    assign rd_data = rd_reg;
endmodule

// ===== hdl/pair_difference_histogram_top.sv =====
// pair difference histogram top level: controller, shared cordic, two histogram memories
// depends on pdh_pkg, pdh_if, pdh_cordic, pdh_hist_mem
`timescale 1ns / 1ps
//
// channel  dir  content
// req      in   request type, pair kinematics and codes, bin index
// res      out  status, bin counts, pair total, bins hit
// cfg      in   species code
//
// one request at a time; a counted pair runs two 16-step arctangents on the single cordic,
// then a read-modify-write of the angle memory and, for an in-range rapidity bin, of the
// rapidity memory; a read goes through a memory read state and a bin state to its result,
// a clear through a pass over max(bins) addresses; a skipped, mismatched or unused request
// goes straight to its result
// after reset a clearing pass over max(RAPIDITY_BINS, ANGLE_BINS) addresses runs before the
// first request; a stalled result holds the controller, the next request is taken in the
// cycle after the result transfer

module pair_difference_histogram_top #(
    parameter int RAPIDITY_BINS = 20,
    parameter int ANGLE_BINS    = 24
) (
    input logic       clk,
    input logic       rst_n,
    pdh_req_if.sink   req,
    pdh_res_if.source res,
    pdh_cfg_if.sink   cfg
);
    import pdh_pkg::*;

    localparam int RAW = (RAPIDITY_BINS > 1) ? $clog2(RAPIDITY_BINS) : 1;
    localparam int AAW = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
    localparam int MaxBins = (RAPIDITY_BINS > ANGLE_BINS) ? RAPIDITY_BINS : ANGLE_BINS;
    localparam int CW = $clog2(MaxBins + 1);

    state_t state_reg, state_next;
    logic [30:0] species_reg;
    logic [31:0] total_reg, total_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic        boot_reg, boot_next;
    logic [1:0]  req_reg;
    logic signed [15:0] ry1_reg, ry2_reg, mx2_reg, my2_reg;
    logic [4:0]  bin_reg;
    logic [15:0] a1_reg;
    logic [8:0]  rbin_reg, rbin_next;
    logic [8:0]  abin_reg, abin_next;
    logic [1:0]  st_reg, st_next;
    logic [31:0] rc_reg, rc_next, ac_reg, ac_next;
    logic        rok_reg;

    logic        cor_start, cor_done;
    logic signed [15:0] cor_x, cor_y;
    logic [15:0] cor_angle;

    logic          rwe, awe;
    logic [RAW-1:0] rwa, rra;
    logic [AAW-1:0] awa, ara;
    logic [31:0]   rwd, awd, rrd, ard;

    logic signed [16:0] rdiff;
    logic [16:0] rabs;
    logic [25:0] rprod;
    logic [15:0] da, dfold;
    logic [24:0] aprod;
    logic signed [32:0] c1, c2;
    logic [32:0] mag;

    assign cfg.ready = (state_reg == S_IDLE);
    assign req.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            species_reg <= 31'd211;
        else if (cfg.valid && cfg.ready)
            species_reg <= cfg.species_code;
    end

    assign cor_x = (state_reg == S_IDLE) ? req.momx_first : mx2_reg;
    assign cor_y = (state_reg == S_IDLE) ? req.momy_first : my2_reg;

    pdh_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .vec_x (cor_x),
        .vec_y (cor_y),
        .done  (cor_done),
        .angle (cor_angle)
    );

    pdh_hist_mem #(.DEPTH(RAPIDITY_BINS), .AW(RAW)) u_rap_mem (
        .clk(clk), .wr_en(rwe), .wr_addr(rwa), .wr_data(rwd), .rd_addr(rra), .rd_data(rrd)
    );

    pdh_hist_mem #(.DEPTH(ANGLE_BINS), .AW(AAW)) u_ang_mem (
        .clk(clk), .wr_en(awe), .wr_addr(awa), .wr_data(awd), .rd_addr(ara), .rd_data(ard)
    );

    always_comb
    begin
        c1 = 33'(req.code_first);
        c2 = 33'(req.code_second);
        mag = c1[32] ? 33'(-c1) : 33'(c1);
        rdiff = 17'(ry1_reg) - 17'(ry2_reg);
        rabs = rdiff[16] ? 17'(-rdiff) : 17'(rdiff);
        rprod = 26'(rabs) * 26'(RAPIDITY_BINS);
        da = a1_reg - cor_angle;
        dfold = (da > 16'd32768) ? 16'(17'd65536 - 17'(da)) : da;
        aprod = 25'(dfold) * 25'(ANGLE_BINS);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req.valid)
                begin
                    case (req_t'(req.req_type))
                        REQ_ACCUM:
                            if (mag == 33'(species_reg) && c2 == -c1)
                                state_next = S_CORDIC1;
                            else
                                state_next = S_OUT;
                        REQ_READ:  state_next = S_READ;
                        REQ_CLEAR: state_next = S_CLEAR;
                        default:   state_next = S_OUT;
                    endcase
                end
            S_CLEAR:
                if (clr_reg == CW'(MaxBins - 1))
                    state_next = boot_reg ? S_IDLE : S_OUT;
            S_CORDIC1: if (cor_done) state_next = S_CORDIC2;
            S_CORDIC2: if (cor_done) state_next = S_BIN;
            S_BIN:     state_next = (req_reg == REQ_READ) ? S_OUT : S_WRITE;
            S_READ:    state_next = S_BIN;
            S_WRITE:   state_next = S_OUT;
            S_OUT:     if (res.ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cor_start = 1'b0;
        rwe = 1'b0; awe = 1'b0;
        rwa = rbin_reg[RAW-1:0]; awa = abin_reg[AAW-1:0];
        rwd = (&rrd) ? rrd : rrd + 32'd1;
        awd = (&ard) ? ard : ard + 32'd1;
        rra = rbin_reg[RAW-1:0]; ara = abin_reg[AAW-1:0];
        total_next = total_reg;
        clr_next = clr_reg;
        boot_next = boot_reg;
        rbin_next = rbin_reg; abin_next = abin_reg;
        st_next = st_reg; rc_next = rc_reg; ac_next = ac_reg;
        case (state_reg)
            S_IDLE:
            begin
                clr_next = '0;
                st_next = ST_DONE; rc_next = '0; ac_next = '0;
                rbin_next = '0; abin_next = '0;
                if (req.valid)
                begin
                    case (req_t'(req.req_type))
                        REQ_ACCUM:
                            if (mag != 33'(species_reg))
                                st_next = ST_SKIP;
                            else if (c2 != -c1)
                                st_next = ST_MISMATCH;
                            else
                                cor_start = 1'b1;
                        REQ_READ:
                        begin
                            rbin_next = 9'(req.bin_index);
                            abin_next = 9'(req.bin_index);
                            if (!(32'(req.bin_index) < RAPIDITY_BINS)
                                && !(32'(req.bin_index) < ANGLE_BINS))
                                st_next = ST_NOBIN;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR:
            begin
                rwd = '0; awd = '0;
                rwa = clr_reg[RAW-1:0]; awa = clr_reg[AAW-1:0];
                rwe = 32'(clr_reg) < RAPIDITY_BINS;
                awe = 32'(clr_reg) < ANGLE_BINS;
                clr_next = clr_reg + CW'(1);
                total_next = '0;
                if (clr_reg == CW'(MaxBins - 1))
                    boot_next = 1'b0;
            end
            S_CORDIC1:
                cor_start = cor_done;
            S_CORDIC2:
                if (cor_done)
                begin
                    rbin_next = (rprod[25:13] < 13'(RAPIDITY_BINS))
                        ? 9'(rprod[25:13]) : 9'(RAPIDITY_BINS);
                    abin_next = (aprod[24:15] >= 10'(ANGLE_BINS))
                        ? 9'(ANGLE_BINS - 1) : 9'(aprod[24:15]);
                end
            S_BIN:
                if (req_reg == REQ_READ)
                begin
                    rc_next = rok_reg && (32'(bin_reg) < RAPIDITY_BINS) ? rrd : '0;
                    ac_next = (32'(bin_reg) < ANGLE_BINS) ? ard : '0;
                end
            S_WRITE:
            begin
                rwe = 32'(rbin_reg) < RAPIDITY_BINS;
                awe = 1'b1;
                total_next = (&total_reg) ? total_reg : total_reg + 32'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            total_reg <= '0;
            clr_reg   <= '0;
            boot_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            clr_reg   <= clr_next;
            boot_reg  <= boot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rbin_reg <= rbin_next;
        abin_reg <= abin_next;
        st_reg <= st_next;
        rc_reg <= rc_next;
        ac_reg <= ac_next;
        rok_reg <= 1'b1;
        if (state_reg == S_CORDIC1 && cor_done)
            a1_reg <= cor_angle;
        if (state_reg == S_IDLE && req.valid)
        begin
            req_reg <= req.req_type;
            bin_reg <= req.bin_index;
            ry1_reg <= req.rapidity_first;
            ry2_reg <= req.rapidity_second;
            mx2_reg <= req.momx_second;
            my2_reg <= req.momy_second;
        end
    end

    assign res.valid = (state_reg == S_OUT);
    assign res.status = st_reg;
    assign res.rapidity_count = rc_reg;
    assign res.angle_count = ac_reg;
    assign res.pairs_counted = total_reg;
    assign res.rapidity_bin_hit = (st_reg == ST_DONE && req_reg == REQ_ACCUM)
        ? rbin_reg[4:0] : 5'd0;
    assign res.angle_bin_hit = (st_reg == ST_DONE && req_reg == REQ_ACCUM)
        ? abin_reg[4:0] : 5'd0;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready) else $error("request taken while busy");
    a_write_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (state_reg == S_OUT)) else $error("write not followed by result");
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (total_reg == $past(total_reg) + 32'd1)
        || (&total_reg) || ($past(total_reg) == 32'hFFFF_FFFF)) else $error("pair total step");
endmodule

// ===== dv/pair_difference_histogram_top_tb.sv =====
// testbench for pair_difference_histogram_top: directed and random pair, read, clear and unused requests
// checked against an in-bench prediction of both histograms and the pair total
// depends on pdh_pkg, pdh_if and the rtl of the block
`timescale 1ns / 1ps

module pair_difference_histogram_top_tb;
    import pdh_pkg::*;

    localparam int RapBins = 20;
    localparam int AngBins = 24;
    localparam longint CycleLimit = 2000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rapidity_count;
        logic [31:0] angle_count;
        logic [31:0] pairs_counted;
        logic [4:0]  rapidity_bin_hit;
        logic [4:0]  angle_bin_hit;
    } histo_result_t;

    class histo_scoreboard;
        logic [31:0]   rap_hist[RapBins];
        logic [31:0]   ang_hist[AngBins];
        logic [31:0]   total;
        logic [30:0]   species;
        histo_result_t pending[$];
        int            errors;
        int            checked;

        function new();
            clear_all();
            species = 31'd211;
            errors = 0;
            checked = 0;
        endfunction

        function void clear_all();
            foreach (rap_hist[i]) rap_hist[i] = '0;
            foreach (ang_hist[i]) ang_hist[i] = '0;
            total = '0;
        endfunction

        function logic [31:0] sat_inc(logic [31:0] c);
            return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
        endfunction

        function logic [15:0] azimuth(logic signed [15:0] mx, logic signed [15:0] my);
            int x;
            int y;
            int xs;
            int ys;
            logic [31:0] z;
            x = mx;
            y = my;
            z = 0;
            if (x == 0 && y == 0)
                return 16'd0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 32768;
            end
            x = x * 256;
            y = y * 256;
            for (int i = 0; i < 16; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_bam(i[3:0]);
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_bam(i[3:0]);
                end
            end
            return z[15:0];
        endfunction

        function void note_request(req_t kind, logic signed [15:0] r1, logic signed [15:0] x1,
                                   logic signed [15:0] y1, logic signed [31:0] c1,
                                   logic signed [15:0] r2, logic signed [15:0] x2,
                                   logic signed [15:0] y2, logic signed [31:0] c2,
                                   logic [4:0] bidx);
            histo_result_t e;
            longint mag;
            longint ad;
            longint rb;
            logic [15:0] da;
            logic [16:0] df;
            longint ab;
            e = '0;
            if (kind == REQ_ACCUM)
            begin
                mag = c1;
                if (mag < 0) mag = -mag;
                if (mag != longint'(species))
                    e.status = ST_SKIP;
                else if (longint'(c2) != -longint'(c1))
                    e.status = ST_MISMATCH;
                else
                begin
                    ad = longint'(r1) - longint'(r2);
                    if (ad < 0) ad = -ad;
                    rb = (ad * RapBins) >> 13;
                    da = azimuth(x1, y1) - azimuth(x2, y2);
                    df = (da > 16'd32768) ? 17'd65536 - da : {1'b0, da};
                    ab = (longint'(df) * AngBins) >> 15;
                    if (ab >= AngBins) ab = AngBins - 1;
                    total = sat_inc(total);
                    if (rb < RapBins)
                    begin
                        rap_hist[rb] = sat_inc(rap_hist[rb]);
                        e.rapidity_bin_hit = rb[4:0];
                    end
                    else
                        e.rapidity_bin_hit = 5'(RapBins);
                    ang_hist[ab] = sat_inc(ang_hist[ab]);
                    e.angle_bin_hit = ab[4:0];
                end
            end
            else if (kind == REQ_READ)
            begin
                if (bidx < RapBins) e.rapidity_count = rap_hist[bidx];
                if (bidx < AngBins) e.angle_count = ang_hist[bidx];
                if (bidx >= RapBins && bidx >= AngBins) e.status = ST_NOBIN;
            end
            else if (kind == REQ_CLEAR)
                clear_all();
            e.pairs_counted = total;
            pending.push_back(e);
        endfunction

        function void check_result(histo_result_t got);
            histo_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.rapidity_count !== e.rapidity_count)
            begin
                $error("rapidity_count exp %0d got %0d", e.rapidity_count, got.rapidity_count);
                errors++;
            end
            if (got.angle_count !== e.angle_count)
            begin
                $error("angle_count exp %0d got %0d", e.angle_count, got.angle_count);
                errors++;
            end
            if (got.pairs_counted !== e.pairs_counted)
            begin
                $error("pairs_counted exp %0d got %0d", e.pairs_counted, got.pairs_counted);
                errors++;
            end
            if (got.rapidity_bin_hit !== e.rapidity_bin_hit)
            begin
                $error("rapidity_bin_hit exp %0d got %0d", e.rapidity_bin_hit,
                       got.rapidity_bin_hit);
                errors++;
            end
            if (got.angle_bin_hit !== e.angle_bin_hit)
            begin
                $error("angle_bin_hit exp %0d got %0d", e.angle_bin_hit, got.angle_bin_hit);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    longint cycles = 0;
    bit stim_done = 1'b0;
    histo_scoreboard board;

    pdh_req_if req ();
    pdh_res_if res ();
    pdh_cfg_if cfg ();

    pair_difference_histogram_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // valid stays high into a back-to-back transfer, so it is dropped only for a real gap
    task automatic pause(int n);
        if (n > 0)
        begin
            req.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send(req_t kind, logic signed [15:0] r1, logic signed [15:0] x1,
                        logic signed [15:0] y1, logic signed [31:0] c1,
                        logic signed [15:0] r2, logic signed [15:0] x2,
                        logic signed [15:0] y2, logic signed [31:0] c2, logic [4:0] bidx);
        req.valid <= 1'b1;
        req.req_type <= kind;
        req.rapidity_first <= r1;
        req.momx_first <= x1;
        req.momy_first <= y1;
        req.code_first <= c1;
        req.rapidity_second <= r2;
        req.momx_second <= x2;
        req.momy_second <= y2;
        req.code_second <= c2;
        req.bin_index <= bidx;
        do @(posedge clk); while (!req.ready);
        board.note_request(kind, r1, x1, y1, c1, r2, x2, y2, c2, bidx);
    endtask

    task automatic send_pair(logic signed [15:0] r1, logic signed [15:0] x1,
                             logic signed [15:0] y1, logic signed [15:0] r2,
                             logic signed [15:0] x2, logic signed [15:0] y2, bit neg);
        logic signed [31:0] c;
        c = {1'b0, board.species};
        if (neg) c = -c;
        send(REQ_ACCUM, r1, x1, y1, c, r2, x2, y2, -c, 5'd0);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_species(logic [30:0] code);
        drain();
        cfg.valid <= 1'b1;
        cfg.species_code <= code;
        do @(posedge clk); while (!cfg.ready);
        board.species = code;
        cfg.valid <= 1'b0;
    endtask

    task automatic random_item();
        int p;
        logic signed [15:0] r1, x1, y1, r2, x2, y2;
        logic signed [31:0] c, c1, c2;
        logic [4:0] b;
        bit neg;
        p = $urandom_range(0, 99);
        r1 = 16'($urandom);
        x1 = 16'($urandom);
        y1 = 16'($urandom);
        r2 = 16'($urandom);
        x2 = 16'($urandom);
        y2 = 16'($urandom);
        c1 = 32'($urandom);
        c2 = 32'($urandom);
        b = 5'($urandom);
        neg = 1'($urandom_range(0, 1));
        if (p < 70)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                r1 = 16'(int'($urandom_range(0, 16383)) - 8192);
                r2 = 16'(int'($urandom_range(0, 16383)) - 8192);
            end
            send_pair(r1, x1, y1, r2, x2, y2, neg);
        end
        else if (p < 78)
        begin
            c = {1'b0, board.species};
            send(REQ_ACCUM, r1, x1, y1, c, r2, x2, y2, neg ? c : c2, 5'd0);
        end
        else if (p < 84)
            send(REQ_ACCUM, r1, x1, y1, c1, r2, x2, y2, c2, b);
        else if (p < 97)
            send(REQ_READ, r1, x1, y1, c1, r2, x2, y2, c2, b);
        else if (p < 98)
            send(REQ_CLEAR, r1, x1, y1, c1, r2, x2, y2, c2, b);
        else
            send(REQ_NONE, r1, x1, y1, c1, r2, x2, y2, c2, b);
    endtask

    initial
    begin
        board = new();
        req.valid = 1'b0;
        req.req_type = REQ_NONE;
        req.rapidity_first = '0;
        req.momx_first = '0;
        req.momy_first = '0;
        req.code_first = '0;
        req.rapidity_second = '0;
        req.momx_second = '0;
        req.momy_second = '0;
        req.code_second = '0;
        req.bin_index = '0;
        cfg.valid = 1'b0;
        cfg.species_code = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero vectors, angle at pi, range overflow, codes, reads, an unused request, a clear
        send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_pair(16'sd32767, 16'sd100, 16'sd0, -16'sd32768, -16'sd100, 16'sd0, 1'b1);
        send_pair(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                  16'sd32767, 1'b0);
        send_pair(16'sd8191, 16'sd0, 16'sd5, 16'sd0, 16'sd0, -16'sd5, 1'b0);
        send_pair(16'sd8192, 16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 1'b1);
        send_pair(-16'sd1, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0);
        send(REQ_ACCUM, 16'sd0, 16'sd1, 16'sd1, 32'sd211, 16'sd0, 16'sd1, 16'sd1, 32'sd211,
             5'd0);
        send(REQ_ACCUM, 16'sd0, 16'sd1, 16'sd1, 32'sh8000_0000, 16'sd0, 16'sd1, 16'sd1,
             32'sh8000_0000, 5'd0);
        send(REQ_ACCUM, 16'sd0, 16'sd1, 16'sd1, 32'sh7FFF_FFFF, 16'sd0, 16'sd1, 16'sd1,
             32'sh8000_0001, 5'd0);
        for (int b = 0; b < 32; b += 3)
            send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, '0, b[4:0]);
        send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, '0, 5'd31);
        send(REQ_NONE, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        send(REQ_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        send(REQ_READ, '0, '0, '0, '0, '0, '0, '0, '0, 5'd0);

        // random phases across several species settings, extremes included
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                1: write_species(31'd0);
                2: write_species(31'h7FFF_FFFF);
                3: write_species(31'($urandom));
                4: write_species(31'd211);
                default: ;
            endcase
            for (int n = 0; n < 260; n++)
            begin
                if (n == 130) drain();
                pause(gap_len());
                random_item();
            end
        end
        req.valid <= 1'b0;
        stim_done = 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if ($urandom_range(0, 99) < 10)
            res.ready <= 1'b0;
        else if ($urandom_range(0, 199) == 0)
            res.ready <= 1'b0;
        else
            res.ready <= 1'b1;
        if (rst_n && res.valid && res.ready)
            board.check_result({res.status, res.rapidity_count, res.angle_count,
                                res.pairs_counted, res.rapidity_bin_hit, res.angle_bin_hit});
    end

    initial
    begin
        wait (stim_done);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d results over five species settings, reads inside and past",
                 board.checked);
        $display("both histograms, clears, code mismatches, skips and unused requests");
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end
endmodule
